FILE: rtl/spx_pkg.sv
`default_nettype none
package spx_pkg;

	localparam int DISCARD_ITEMS_DEF = 20;
	localparam int WORDS_OUT_DEF     = 4;
	localparam int PAYLOAD_MAX_DEF   = 8;
	localparam int JOBQ_DEPTH        = 4;

	// input item kinds
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// request modes
	localparam logic [1:0] MODE_READ  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;

	// result kinds
	localparam logic [1:0] OUT_TX     = 2'd0;
	localparam logic [1:0] OUT_WORD   = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	// completion status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CKSUM   = 3'd1;
	localparam logic [2:0] ST_ADDR    = 3'd2;
	localparam logic [2:0] ST_TYPE    = 3'd3;
	localparam logic [2:0] ST_NO_P    = 3'd4;
	localparam logic [2:0] ST_NO_N    = 3'd5;
	localparam logic [2:0] ST_NO_S    = 3'd6;
	localparam logic [2:0] ST_TIMEOUT = 3'd7;

	localparam logic [7:0]  PT_DATA  = 8'h80;
	localparam logic [7:0]  PT_BATCH = 8'h40;
	localparam logic [7:0]  CH_S     = 8'h73;
	localparam logic [7:0]  CH_N     = 8'h6e;
	localparam logic [7:0]  CH_P     = 8'h70;
	localparam logic [15:0] SNP_SUM  = 16'd337;
	localparam logic [3:0]  SINGLE_LEN = 4'd4;
	localparam logic [2:0]  REQ_LAST   = 3'd6;

	typedef enum logic [3:0] {
		PH_IDLE, PH_S, PH_N, PH_P, PH_TYPE, PH_ADDR, PH_DATA, PH_CKH, PH_CKL, PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		JOB_REQ, JOB_STAT, JOB_DONE
	} job_kind_t;

	// JOB_REQ: data[63:56] type, [55:48] address, [47:32] checksum
	// JOB_DONE: data holds the payload bytes, byte 0 at the top
	typedef struct packed {
		job_kind_t   kind;
		logic [2:0]  status;
		logic [63:0] data;
	} job_t;

	function automatic logic [7:0] batch_bits(input logic [3:0] batch);
		logic [7:0] r;
		r = (batch != 4'd0) ? (PT_BATCH | {4'h0, batch}) : 8'h00;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/spx_front.sv
`default_nettype none
module spx_front #(
	parameter int DISCARD_ITEMS = spx_pkg::DISCARD_ITEMS_DEF,
	parameter int PAYLOAD_MAX   = spx_pkg::PAYLOAD_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  reg_addr,
	input  wire logic [3:0]  batch_len,
	input  wire logic [7:0]  rx_byte,
	output logic             job_wr,
	output spx_pkg::job_t    job,
	input  wire logic        jobq_full
);

	localparam int IDX_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam logic [3:0] PAY_LIM = 4'(PAYLOAD_MAX);
	localparam logic [4:0] DISC_INIT = 5'(DISCARD_ITEMS);
	localparam spx_pkg::phase_t FAIL_PH = (DISCARD_ITEMS != 0) ? spx_pkg::PH_DISCARD
		: spx_pkg::PH_IDLE;

	spx_pkg::phase_t phase_q, phase_d;
	logic [1:0]  req_mode_q;
	logic [7:0]  req_addr_q;
	logic [3:0]  req_batch_q;
	logic [7:0]  pay_q [PAYLOAD_MAX];
	logic [11:0] psum_q;
	logic [7:0]  ckh_q;
	logic [3:0]  bcnt_q;
	logic [4:0]  disc_q;

	logic        acc, is_start, is_rx, is_tmo;
	logic [7:0]  rx_b, exp_type, pt_req;
	logic [3:0]  bcnt_nx, need;
	logic [15:0] want, got, cks_req;
	logic        bad;
	logic [2:0]  bad_st;
	logic [63:0] words;

	assign full     = jobq_full;
	assign acc      = push && !jobq_full;
	assign is_start = acc && (kind == spx_pkg::KIND_START);
	assign is_tmo   = kind == spx_pkg::KIND_TIMEOUT;
	assign is_rx    = acc && (kind == spx_pkg::KIND_BYTE || is_tmo);
	// a late timeout counts as a zero byte
	assign rx_b     = (kind == spx_pkg::KIND_BYTE) ? rx_byte : 8'h00;

	assign exp_type = (req_mode_q == spx_pkg::MODE_READ)
		? (spx_pkg::PT_DATA | spx_pkg::batch_bits(req_batch_q)) : 8'h00;
	assign bcnt_nx  = bcnt_q + 4'd1;
	assign need     = (req_batch_q != 4'd0) ? req_batch_q : spx_pkg::SINGLE_LEN;
	assign want     = spx_pkg::SNP_SUM + {8'h00, exp_type} + {8'h00, req_addr_q}
		+ {4'h0, psum_q};
	assign got      = {ckh_q, rx_b};

	always_comb begin
		unique case (mode)
			spx_pkg::MODE_READ:  pt_req = spx_pkg::batch_bits(batch_len);
			spx_pkg::MODE_WRITE: pt_req = spx_pkg::PT_DATA | spx_pkg::batch_bits(batch_len);
			default:             pt_req = 8'h00;
		endcase
	end
	assign cks_req = spx_pkg::SNP_SUM + {8'h00, pt_req} + {8'h00, reg_addr};

	always_comb begin
		words = '0;
		for (int j = 0; j < PAYLOAD_MAX; j++) begin
			words[63 - 8 * j -: 8] = pay_q[j];
		end
	end

	// response byte check for the current phase
	always_comb begin
		bad    = 1'b0;
		bad_st = spx_pkg::ST_OK;
		unique case (phase_q)
			spx_pkg::PH_S: begin
				bad    = !is_tmo && (rx_b != spx_pkg::CH_S);
				bad_st = spx_pkg::ST_NO_S;
			end
			spx_pkg::PH_N: begin
				bad    = rx_b != spx_pkg::CH_N;
				bad_st = spx_pkg::ST_NO_N;
			end
			spx_pkg::PH_P: begin
				bad    = rx_b != spx_pkg::CH_P;
				bad_st = spx_pkg::ST_NO_P;
			end
			spx_pkg::PH_TYPE: begin
				bad    = rx_b != exp_type;
				bad_st = spx_pkg::ST_TYPE;
			end
			spx_pkg::PH_ADDR: begin
				bad    = rx_b != req_addr_q;
				bad_st = spx_pkg::ST_ADDR;
			end
			spx_pkg::PH_CKL: begin
				bad    = got != want;
				bad_st = spx_pkg::ST_CKSUM;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (is_start) begin
			phase_d = spx_pkg::PH_S;
		end else if (is_rx) begin
			unique case (phase_q)
				spx_pkg::PH_IDLE: phase_d = spx_pkg::PH_IDLE;
				spx_pkg::PH_S: begin
					if (is_tmo) phase_d = spx_pkg::PH_IDLE;
					else if (bad) phase_d = FAIL_PH;
					else phase_d = spx_pkg::PH_N;
				end
				spx_pkg::PH_N:    phase_d = bad ? FAIL_PH : spx_pkg::PH_P;
				spx_pkg::PH_P:    phase_d = bad ? FAIL_PH : spx_pkg::PH_TYPE;
				spx_pkg::PH_TYPE: phase_d = bad ? FAIL_PH : spx_pkg::PH_ADDR;
				spx_pkg::PH_ADDR: phase_d = bad ? FAIL_PH : spx_pkg::PH_DATA;
				spx_pkg::PH_DATA: begin
					if (bcnt_nx >= need) phase_d = spx_pkg::PH_CKH;
				end
				spx_pkg::PH_CKH:  phase_d = spx_pkg::PH_CKL;
				spx_pkg::PH_CKL:  phase_d = bad ? FAIL_PH : spx_pkg::PH_IDLE;
				spx_pkg::PH_DISCARD: begin
					if (disc_q <= 5'd1) phase_d = spx_pkg::PH_IDLE;
				end
				default: phase_d = spx_pkg::PH_IDLE;
			endcase
		end
	end

	// jobs for the back end
	always_comb begin
		job_wr = 1'b0;
		job    = '0;
		if (is_start) begin
			job_wr            = 1'b1;
			job.kind          = spx_pkg::JOB_REQ;
			job.data[63:56]   = pt_req;
			job.data[55:48]   = reg_addr;
			job.data[47:32]   = cks_req;
		end else if (is_rx && phase_q != spx_pkg::PH_IDLE) begin
			if (phase_q == spx_pkg::PH_S && is_tmo) begin
				job_wr     = 1'b1;
				job.kind   = spx_pkg::JOB_STAT;
				job.status = spx_pkg::ST_TIMEOUT;
			end else if (bad) begin
				job_wr     = 1'b1;
				job.kind   = spx_pkg::JOB_STAT;
				job.status = bad_st;
			end else if (phase_q == spx_pkg::PH_CKL) begin
				job_wr     = 1'b1;
				job.kind   = spx_pkg::JOB_DONE;
				job.status = spx_pkg::ST_OK;
				job.data   = words;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= spx_pkg::PH_IDLE;
			req_mode_q  <= '0;
			req_addr_q  <= '0;
			req_batch_q <= '0;
			psum_q      <= '0;
			ckh_q       <= '0;
			bcnt_q      <= '0;
			disc_q      <= '0;
		end else begin
			phase_q <= phase_d;
			if (is_start) begin
				req_mode_q  <= mode;
				req_addr_q  <= reg_addr;
				req_batch_q <= batch_len;
				psum_q      <= '0;
				ckh_q       <= '0;
				bcnt_q      <= '0;
				disc_q      <= '0;
			end else if (is_rx) begin
				if (phase_q == spx_pkg::PH_DATA) begin
					psum_q <= psum_q + {4'h0, rx_b};
					bcnt_q <= bcnt_nx;
				end
				if (phase_q == spx_pkg::PH_CKH) ckh_q <= rx_b;
				if (phase_q == spx_pkg::PH_DISCARD && disc_q != 5'd0) disc_q <= disc_q - 5'd1;
				if (bad) disc_q <= DISC_INIT;
			end
		end
	end

	// payload bytes: clear on start, store the first ones received
	always_ff @(posedge clk) begin
		if (is_start) begin
			for (int j = 0; j < PAYLOAD_MAX; j++) begin
				pay_q[j] <= 8'h00;
			end
		end else if (is_rx && phase_q == spx_pkg::PH_DATA && bcnt_q < PAY_LIM) begin
			pay_q[bcnt_q[IDX_W-1:0]] <= rx_b;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/spx_jobq.sv
`default_nettype none
module spx_jobq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire spx_pkg::job_t wdata,
	output logic               full,
	input  wire logic          rd,
	output spx_pkg::job_t      rdata,
	output logic               empty
);

	localparam int DEPTH = spx_pkg::JOBQ_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	spx_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full  = cnt_q == CNT_FULL;
	assign empty = cnt_q == '0;
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
			if (do_rd) rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + CNT_W'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> !full) else $error("job written into a full queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL) else $error("job queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_FULL) |-> wp_q == rp_q)
		else $error("job queue pointers disagree with count");

endmodule
`default_nettype wire

FILE: rtl/spx_back.sv
`default_nettype none
module spx_back #(
	parameter int WORDS_OUT = spx_pkg::WORDS_OUT_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spx_pkg::job_t job,
	input  wire logic          job_empty,
	output logic               job_rd,
	output logic               empty,
	input  wire logic          pop,
	output logic [1:0]         out_kind,
	output logic [7:0]         tx_byte,
	output logic [1:0]         word_index,
	output logic [15:0]        data_word,
	output logic [2:0]         status,
	output logic               last
);

	localparam logic [2:0] WLIM = 3'(WORDS_OUT);

	logic [2:0]  cnt_q;
	logic        ov_q;
	logic [1:0]  kind_q;
	logic [7:0]  tx_q;
	logic [1:0]  wi_q;
	logic [15:0] dw_q;
	logic [2:0]  st_q;
	logic        last_q;

	logic        adv, take;
	logic [1:0]  r_kind, r_wi;
	logic [7:0]  r_tx;
	logic [15:0] r_dw;
	logic [2:0]  r_st;
	logic        r_last;

	assign adv  = !ov_q || pop;
	assign take = adv && !job_empty;

	// result number cnt_q of the job at the queue head
	always_comb begin
		r_kind = spx_pkg::OUT_STATUS;
		r_tx   = 8'h00;
		r_wi   = 2'd0;
		r_dw   = 16'h0000;
		r_st   = spx_pkg::ST_OK;
		r_last = 1'b1;
		unique case (job.kind)
			spx_pkg::JOB_REQ: begin
				r_kind = spx_pkg::OUT_TX;
				r_last = cnt_q == spx_pkg::REQ_LAST;
				unique case (cnt_q)
					3'd0:    r_tx = spx_pkg::CH_S;
					3'd1:    r_tx = spx_pkg::CH_N;
					3'd2:    r_tx = spx_pkg::CH_P;
					3'd3:    r_tx = job.data[63:56];
					3'd4:    r_tx = job.data[55:48];
					3'd5:    r_tx = job.data[47:40];
					default: r_tx = job.data[39:32];
				endcase
			end
			spx_pkg::JOB_STAT: begin
				r_st = job.status;
			end
			spx_pkg::JOB_DONE: begin
				if (cnt_q < WLIM) begin
					r_kind = spx_pkg::OUT_WORD;
					r_last = 1'b0;
					r_wi   = cnt_q[1:0];
					unique case (cnt_q[1:0])
						2'd0: r_dw = job.data[63:48];
						2'd1: r_dw = job.data[47:32];
						2'd2: r_dw = job.data[31:16];
						2'd3: r_dw = job.data[15:0];
					endcase
				end
			end
			default: ;
		endcase
	end

	assign job_rd = take && r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (adv) ov_q <= !job_empty;
			if (take) cnt_q <= r_last ? 3'd0 : cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= r_kind;
			tx_q   <= r_tx;
			wi_q   <= r_wi;
			dw_q   <= r_dw;
			st_q   <= r_st;
			last_q <= r_last;
		end
	end

	assign empty      = !ov_q;
	assign out_kind   = kind_q;
	assign tx_byte    = tx_q;
	assign word_index = wi_q;
	assign data_word  = dw_q;
	assign status     = st_q;
	assign last       = last_q;

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		job_empty |-> cnt_q == 3'd0) else $error("step count left over with no job");

	a_stat_single: assert property (@(posedge clk) disable iff (!arst_n)
		(!job_empty && job.kind == spx_pkg::JOB_STAT) |-> cnt_q == 3'd0)
		else $error("status job expanded past one result");

	a_req_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!job_empty && job.kind == spx_pkg::JOB_REQ) |-> cnt_q <= spx_pkg::REQ_LAST)
		else $error("request job ran past its last byte");

endmodule
`default_nettype wire

FILE: rtl/imu_serial_packet_exchange_unit.sv
`default_nettype none
// Host side of a framed "snp" serial register exchange. Push a start item to
// get the seven request bytes, then push each received byte (or a timeout) of
// the response; the block checks header, type, address, data and the 16-bit
// additive checksum and reports data words plus a status, or an error status
// after which, unless it is the timeout status, the next DISCARD_ITEMS received
// items are dropped. The front end takes one input item per clock while full is
// low and classifies it in that cycle; a four-entry job queue feeds the back
// end, which delivers one result per clock while the consumer pops, through a
// registered output behind the job queue. A start item therefore yields seven
// results, a good response WORDS_OUT + 1, an error one, and other items none;
// full rises when the job queue fills, either behind a stalled consumer or
// when start items arrive faster than their seven results drain.
module imu_serial_packet_exchange_unit #(
	parameter int DISCARD_ITEMS = spx_pkg::DISCARD_ITEMS_DEF,
	parameter int WORDS_OUT     = spx_pkg::WORDS_OUT_DEF,
	parameter int PAYLOAD_MAX   = spx_pkg::PAYLOAD_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  kind,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  reg_addr,
	input  wire logic [3:0]  batch_len,
	input  wire logic [7:0]  rx_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       out_kind,
	output logic [7:0]       tx_byte,
	output logic [1:0]       word_index,
	output logic [15:0]      data_word,
	output logic [2:0]       status,
	output logic             last
);

	spx_pkg::job_t wjob, rjob;
	logic          job_wr, job_rd, jobq_full, jobq_empty;

	spx_front #(
		.DISCARD_ITEMS(DISCARD_ITEMS),
		.PAYLOAD_MAX  (PAYLOAD_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.mode     (mode),
		.reg_addr (reg_addr),
		.batch_len(batch_len),
		.rx_byte  (rx_byte),
		.job_wr   (job_wr),
		.job      (wjob),
		.jobq_full(jobq_full)
	);

	spx_jobq u_jobq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (job_wr),
		.wdata (wjob),
		.full  (jobq_full),
		.rd    (job_rd),
		.rdata (rjob),
		.empty (jobq_empty)
	);

	spx_back #(
		.WORDS_OUT(WORDS_OUT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rjob),
		.job_empty (jobq_empty),
		.job_rd    (job_rd),
		.empty     (empty),
		.pop       (pop),
		.out_kind  (out_kind),
		.tx_byte   (tx_byte),
		.word_index(word_index),
		.data_word (data_word),
		.status    (status),
		.last      (last)
	);

endmodule
`default_nettype wire
